// ===== src/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the station session table
// Holds the request kind and status codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int KIND_W   = 2;
  localparam int NUM_W    = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int OPEN_W   = 5;
  localparam int UCNT_W   = 9;
  localparam int KEY_W    = 3 * NUM_W;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // apb register offsets (byte address bit 2 selects the register)
  localparam logic REG_USER_COUNT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_UNKNOWN_USER = 3'd1,
    ST_ALREADY_OPEN = 3'd2,
    ST_BAD_PASSWORD = 3'd3,
    ST_TABLE_FULL   = 3'd4,
    ST_NOT_OPEN     = 3'd5
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch request, clear scan flags
    logic issue;   // read the next slot
    logic finish;  // commit the request and load the result register
  } sst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_issue;  // the read being issued is the last slot
  } sst_sts_t;

endpackage

// ===== src/sst_ram.sv =====
// ----------------------------------------------------------------------------
// sst_ram: generic single write port, single read port ram
// Read data is registered; contents are undefined until written.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl: request sequencer of the station session table
// Accepts a request, runs the slot scan, then commits and hands the result on.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sst_pkg::sst_cmd_t cmd,
  input  sst_pkg::sst_sts_t sts
);
  import sst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.start  = (state_r == S_IDLE) && in_valid;
    cmd.issue  = (state_r == S_SCAN);
    cmd.finish = (state_r == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a commit loads the result; otherwise a taken result empties the slot
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.last_issue) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/sst_dp.sv =====
// ----------------------------------------------------------------------------
// sst_dp: session table datapath
// Slot store, valid bits, scan compare, request decision and result register.
// ----------------------------------------------------------------------------
module sst_dp #(
  parameter int SESSION_SLOTS = 16,
  parameter int USER_SLOTS    = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sst_pkg::sst_cmd_t               cmd,
  output sst_pkg::sst_sts_t               sts,
  input  logic [sst_pkg::UCNT_W-1:0]      user_count,
  input  logic [sst_pkg::KIND_W-1:0]      in_kind,
  input  logic [sst_pkg::NUM_W-1:0]       in_user_number,
  input  logic [sst_pkg::NUM_W-1:0]       in_net_number,
  input  logic [sst_pkg::NUM_W-1:0]       in_station_number,
  input  logic                            in_password_ok,
  output logic [sst_pkg::STATUS_W-1:0]    out_status,
  output logic [sst_pkg::SLOT_W-1:0]      out_slot,
  output logic [sst_pkg::OPEN_W-1:0]      out_open_sessions,
  output logic [$clog2(SESSION_SLOTS+1)-1:0] open_count
);
  import sst_pkg::*;

  localparam int IW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int CW = $clog2(SESSION_SLOTS + 1);

  // request
  logic [KIND_W-1:0] req_kind_r;
  logic [NUM_W-1:0]  req_user_r;
  logic [NUM_W-1:0]  req_net_r;
  logic [NUM_W-1:0]  req_stn_r;
  logic              req_pw_r;
  logic [KEY_W-1:0]  req_key;

  // scan
  logic [CW-1:0]            cnt_r;
  logic                     cmp_vld_r;
  logic [IW-1:0]            cmp_idx_r;
  logic [SESSION_SLOTS-1:0] valid_r;
  logic [KEY_W-1:0]         rd_data;
  logic                     hit;
  logic                     free;
  logic                     found_r;
  logic [IW-1:0]            found_idx_r;
  logic                     free_found_r;
  logic [IW-1:0]            free_idx_r;
  logic [CW-1:0]            count_r;

  // decision
  logic          known;
  status_t       dec_status;
  logic [IW-1:0] dec_slot;
  logic          do_open;
  logic          do_close;
  logic [CW-1:0] count_nxt;

  // result register
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [OPEN_W-1:0]   out_open_r;

  assign req_key = {req_user_r, req_net_r, req_stn_r};

  sst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SESSION_SLOTS),
    .AW    (IW)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.finish && do_open),
    .waddr (free_idx_r),
    .wdata (req_key),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    sts            = '0;
    sts.last_issue = (cnt_r == CW'(SESSION_SLOTS - 1));
  end

  assign hit  = cmp_vld_r && valid_r[cmp_idx_r] && (rd_data == req_key);
  assign free = cmp_vld_r && !valid_r[cmp_idx_r];

  assign known = (req_user_r < user_count) && (int'(req_user_r) < USER_SLOTS);

  always_comb begin
    dec_status = ST_NOT_OPEN;
    dec_slot   = '0;
    do_open    = 1'b0;
    do_close   = 1'b0;
    unique case (req_kind_r)
      KIND_OPEN: begin
        priority if (!known) begin
          dec_status = ST_UNKNOWN_USER;
        end else if (found_r) begin
          dec_status = ST_ALREADY_OPEN;
        end else if (!req_pw_r) begin
          dec_status = ST_BAD_PASSWORD;
        end else if (!free_found_r) begin
          dec_status = ST_TABLE_FULL;
        end else begin
          dec_status = ST_OK;
          dec_slot   = free_idx_r;
          do_open    = 1'b1;
        end
      end
      KIND_CLOSE: begin
        if (known && found_r) begin
          dec_status = ST_OK;
          dec_slot   = found_idx_r;
          do_close   = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (found_r) begin
          dec_status = ST_OK;
          dec_slot   = found_idx_r;
        end
      end
      default: begin
        dec_status = ST_NOT_OPEN;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_open) begin
      count_nxt = count_r + CW'(1);
    end else if (do_close) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      count_r      <= '0;
    end else begin
      cmp_vld_r <= cmd.issue;
      if (cmd.start) begin
        cnt_r        <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (cmd.issue) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
        if (free) begin
          free_found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count_r <= count_nxt;
        if (do_open) begin
          valid_r[free_idx_r] <= 1'b1;
        end
        if (do_close) begin
          valid_r[found_idx_r] <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_kind_r <= in_kind;
      req_user_r <= in_user_number;
      req_net_r  <= in_net_number;
      req_stn_r  <= in_station_number;
      req_pw_r   <= in_password_ok;
    end
    cmp_idx_r <= cnt_r[IW-1:0];
    // lowest slot wins: only the first hit and the first free slot are kept
    if (hit && !found_r) begin
      found_idx_r <= cmp_idx_r;
    end
    if (free && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (cmd.finish) begin
      out_status_r <= dec_status;
      out_slot_r   <= SLOT_W'(dec_slot);
      out_open_r   <= OPEN_W'(count_nxt);
    end
  end

  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_open_sessions = out_open_r;
  assign open_count        = count_r;

endmodule

// ===== src/station_session_table_unit.sv =====
// ----------------------------------------------------------------------------
// station_session_table_unit: login session table keyed by user and station
// Opens, closes and looks up sessions in a fixed table of session slots.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall with kind, user, network, station and
//   password flag; one transfer is one request
//   result channel: out_valid/out_stall with status, slot and the number of
//   open sessions after the request; every request gives one transfer
//   apb port: user_count at byte address 0, written while the block is idle
// timing
//   the key store has one read port and is walked one slot per cycle; the
//   whole table is scanned, then the result is committed and loaded once
//   the output register is free
//   in_stall is high from the cycle after a transfer until the result is
//   loaded into the output register, so a new request is taken while an
//   earlier result still waits there
// reset and stall
//   rst_n is synchronous; it clears all valid bits, the open count and
//   user_count, so no session is open and every user is unknown
//   while out_stall is high the result holds; if a result is held, a finished
//   request waits in the controller before it commits
// ----------------------------------------------------------------------------
module station_session_table_unit #(
  parameter int SESSION_SLOTS = 16,
  parameter int USER_SLOTS    = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sst_pkg::KIND_W-1:0]   in_kind,
  input  logic [sst_pkg::NUM_W-1:0]    in_user_number,
  input  logic [sst_pkg::NUM_W-1:0]    in_net_number,
  input  logic [sst_pkg::NUM_W-1:0]    in_station_number,
  input  logic                         in_password_ok,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sst_pkg::STATUS_W-1:0] out_status,
  output logic [sst_pkg::SLOT_W-1:0]   out_slot,
  output logic [sst_pkg::OPEN_W-1:0]   out_open_sessions,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sst_pkg::APB_AW-1:0]   paddr,
  input  logic [sst_pkg::APB_DW-1:0]   pwdata,
  output logic [sst_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import sst_pkg::*;

  localparam int CW = $clog2(SESSION_SLOTS + 1);

  sst_cmd_t          cmd;
  sst_sts_t          sts;
  logic [UCNT_W-1:0] user_count_r;
  logic              cfg_wr;
  logic [CW-1:0]     open_count;

  // ---------------------------------------------------------------- apb port
  // register select is address bit 2; the low byte-lane bits are ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_USER_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_count_r <= '0;
    end else if (cfg_wr) begin
      user_count_r <= pwdata[UCNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_USER_COUNT) begin
      prdata = APB_DW'(user_count_r);
    end
  end

  // -------------------------------------------------------------- controller
  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // ---------------------------------------------------------------- datapath
  sst_dp #(
    .SESSION_SLOTS (SESSION_SLOTS),
    .USER_SLOTS    (USER_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .user_count        (user_count_r),
    .in_kind           (in_kind),
    .in_user_number    (in_user_number),
    .in_net_number     (in_net_number),
    .in_station_number (in_station_number),
    .in_password_ok    (in_password_ok),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_open_sessions (out_open_sessions),
    .open_count        (open_count)
  );

  // -------------------------------------------------------------- assertions
`ifndef NO_ASSERTIONS
  // one request at a time: a transfer closes the input until its result
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

  // the open count never passes the table size
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(open_count) <= SESSION_SLOTS)
    else $error("open session count above table size");

  // a failed request reports slot zero
  a_error_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_slot == '0)
    else $error("nonzero slot with error status");

  // the open count only changes when a result is committed
  a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> $stable(open_count))
    else $error("open count changed outside a commit");
`endif

endmodule
